/* sv/wdpu_pkg.sv */
// ----------------------------------------------------------------------------
// wdpu_pkg
// Shared types, codes, CORDIC constants and sine / cosine tables for the
// wind drift position update block.
// ----------------------------------------------------------------------------
package wdpu_pkg;

    // CORDIC depth and datapath widths
    localparam int CORDIC_STAGES = 16;
    localparam int VW            = 36;   // vectoring x / y width
    localparam int ZW            = 26;   // vectoring angle width, degrees Q16
    localparam int XSW           = 20;   // truncated vector sum width
    localparam int CELLS         = 18;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

    localparam longint      GAIN_Q30_L = 64'sd652032874;
    localparam logic [29:0] GAIN_Q30   = 30'd652032874;

    localparam longint ATAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // request kinds
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_PLANE   = 2'd1;
    localparam logic [1:0] REQ_THERMAL = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    // register indexes
    localparam logic [2:0] CFG_X_LOW     = 3'd0;
    localparam logic [2:0] CFG_X_HIGH    = 3'd1;
    localparam logic [2:0] CFG_Y_LOW     = 3'd2;
    localparam logic [2:0] CFG_Y_HIGH    = 3'd3;
    localparam logic [2:0] CFG_ELEV      = 3'd4;
    localparam logic [2:0] CFG_TIME_STEP = 3'd5;

    // move item handed from front to back
    typedef struct packed {
        logic               thermal;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [15:0]        hs;
        logic [8:0]         hd;
        logic [15:0]        ws;
        logic [8:0]         wd;
    } item_t;

    typedef struct packed {
        logic signed [15:0] c;
        logic signed [15:0] s;
    } trig_t;

    typedef logic signed [15:0] q15_tab_t [0:89];

    // rotation CORDIC on a whole degree, rounded to Q1.15
    function automatic logic signed [15:0] cordic_q15(int deg, bit want_sin);
        longint x, y, z, dx, dy, r;
        x = GAIN_Q30_L;
        y = 0;
        z = longint'(deg) * 65536;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_Q16[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_Q16[i];
            end
        end
        r = want_sin ? y : x;
        r = (r >= 0) ? ((r + 16384) >>> 15) : -(((-r) + 16384) >>> 15);
        if (r > 32767) r = 32767;
        if (r < -32767) r = -32767;
        return r[15:0];
    endfunction

    function automatic q15_tab_t build_tab(bit want_sin);
        q15_tab_t t;
        for (int d = 0; d < 90; d++) begin
            t[d] = cordic_q15(d, want_sin);
        end
        return t;
    endfunction

    localparam q15_tab_t COS_TAB = build_tab(1'b0);
    localparam q15_tab_t SIN_TAB = build_tab(1'b1);

    // cosine and sine of 0..359 degrees by quadrant folding
    function automatic trig_t trig_lookup(logic [8:0] d);
        logic [8:0]         a;
        logic [1:0]         q;
        logic signed [15:0] x;
        logic signed [15:0] y;
        trig_t              t;
        if (d < 9'd90) begin
            q = 2'd0; a = d;
        end else if (d < 9'd180) begin
            q = 2'd1; a = d - 9'd90;
        end else if (d < 9'd270) begin
            q = 2'd2; a = d - 9'd180;
        end else begin
            q = 2'd3; a = d - 9'd270;
        end
        x = COS_TAB[a[6:0]];
        y = SIN_TAB[a[6:0]];
        case (q)
            2'd0: begin t.c = x;  t.s = y;  end
            2'd1: begin t.c = -y; t.s = x;  end
            2'd2: begin t.c = -x; t.s = -y; end
            default: begin t.c = y; t.s = -x; end
        endcase
        return t;
    endfunction

endpackage

/* sv/wdpu_front.sv */
// ----------------------------------------------------------------------------
// wdpu_front
// Accepts input words, holds the registers and wind cells, selects the cell
// of a move and pushes move items to the queue.
// ----------------------------------------------------------------------------
module wdpu_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [151:0]         s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 fifo_full,
    output logic                 push_valid,
    output wdpu_pkg::item_t      push_item,
    output logic [7:0]           time_step
);

    logic signed [31:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg, elev_reg;
    logic [7:0]         step_reg;
    logic [15:0]        speed_reg [0:wdpu_pkg::CELLS-1];
    logic [8:0]         dir_reg   [0:wdpu_pkg::CELLS-1];

    logic               accept;
    logic signed [31:0] px, py, pz;
    logic [8:0]         hd_raw, cd_raw, hd_mod, cd_mod;
    logic [4:0]         idx;
    logic [1:0]         xi, yi;
    logic               zi;
    logic [4:0]         cell_sel;

    assign s_tready  = !fifo_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign time_step = step_reg;

    // unpack fields
    assign px     = $signed(s_tdata[31:0]);
    assign py     = $signed(s_tdata[63:32]);
    assign pz     = $signed(s_tdata[95:64]);
    assign hd_raw = s_tdata[120:112];
    assign idx    = s_tdata[125:121];
    assign cd_raw = s_tdata[150:142];
    assign hd_mod = (hd_raw >= 9'd360) ? hd_raw - 9'd360 : hd_raw;
    assign cd_mod = (cd_raw >= 9'd360) ? cd_raw - 9'd360 : cd_raw;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_low_reg  <= '0;
            x_high_reg <= '0;
            y_low_reg  <= '0;
            y_high_reg <= '0;
            elev_reg   <= '0;
            step_reg   <= 8'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                wdpu_pkg::CFG_X_LOW:     x_low_reg  <= $signed(cfg_data);
                wdpu_pkg::CFG_X_HIGH:    x_high_reg <= $signed(cfg_data);
                wdpu_pkg::CFG_Y_LOW:     y_low_reg  <= $signed(cfg_data);
                wdpu_pkg::CFG_Y_HIGH:    y_high_reg <= $signed(cfg_data);
                wdpu_pkg::CFG_ELEV:      elev_reg   <= $signed(cfg_data);
                wdpu_pkg::CFG_TIME_STEP: step_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // store a wind cell, drop indexes past the grid
    always_ff @(posedge aclk) begin
        if (accept && s_tuser == wdpu_pkg::REQ_WRITE && idx < 5'(wdpu_pkg::CELLS)) begin
            speed_reg[idx] <= s_tdata[141:126];
            dir_reg[idx]   <= cd_mod;
        end
    end

    // select the grid cell of the position
    always_comb begin
        xi       = (px < x_low_reg) ? 2'd0 : ((px < x_high_reg) ? 2'd1 : 2'd2);
        yi       = (py < y_low_reg) ? 2'd0 : ((py < y_high_reg) ? 2'd1 : 2'd2);
        zi       = (pz < elev_reg) ? 1'b0 : 1'b1;
        cell_sel = 5'(xi) * 5'd6 + 5'(yi) * 5'd2 + 5'(zi);
    end

    // push moves only; unknown kinds fall away
    assign push_valid = accept &&
                        (s_tuser == wdpu_pkg::REQ_PLANE || s_tuser == wdpu_pkg::REQ_THERMAL);

    always_comb begin
        push_item.thermal = (s_tuser == wdpu_pkg::REQ_THERMAL);
        push_item.px      = px;
        push_item.py      = py;
        push_item.pz      = pz;
        push_item.hs      = s_tdata[111:96];
        push_item.hd      = hd_mod;
        push_item.ws      = speed_reg[cell_sel];
        push_item.wd      = dir_reg[cell_sel];
    end

endmodule

/* sv/wdpu_fifo.sv */
// ----------------------------------------------------------------------------
// wdpu_fifo
// Short queue of move items between the front and the back.
// ----------------------------------------------------------------------------
module wdpu_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wdpu_pkg::item_t push_item,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output wdpu_pkg::item_t head_item
);

    localparam int AW = wdpu_pkg::FIFO_AW;

    wdpu_pkg::item_t mem_reg [0:wdpu_pkg::FIFO_DEPTH-1];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg;

    assign full       = (count_reg == (AW+1)'(wdpu_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid) else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (AW+1)'(wdpu_pkg::FIFO_DEPTH)) else $error("queue count out of range");

endmodule

/* sv/wdpu_back.sv */
// ----------------------------------------------------------------------------
// wdpu_back
// Move pipeline: vector sum, CORDIC vectoring, course rounding and the
// position step, ending in the output register.
// ----------------------------------------------------------------------------
module wdpu_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  wdpu_pkg::item_t head_item,
    output logic            pop,
    input  logic [7:0]      time_step,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [127:0]    m_tdata
);

    localparam int N   = wdpu_pkg::CORDIC_STAGES;
    localparam int VW  = wdpu_pkg::VW;
    localparam int ZW  = wdpu_pkg::ZW;
    localparam int XSW = wdpu_pkg::XSW;

    logic en;

    // stage 1: trig lookups
    logic               v1_reg;
    wdpu_pkg::item_t    pay1_reg;
    wdpu_pkg::trig_t    ht1_reg, wt1_reg;
    // stage 2: products
    logic               v2_reg;
    wdpu_pkg::item_t    pay2_reg;
    logic signed [32:0] pxh2_reg, pxw2_reg, pyh2_reg, pyw2_reg;
    // stage 3: truncated sums
    logic               v3_reg;
    wdpu_pkg::item_t    pay3_reg;
    logic signed [XSW-1:0] xs3_reg, ys3_reg;
    // vectoring stages
    logic               vv_reg   [0:N];
    wdpu_pkg::item_t    vpay_reg [0:N];
    logic               vzero_reg[0:N];
    logic signed [VW-1:0] vx_reg [0:N];
    logic signed [VW-1:0] vy_reg [0:N];
    logic signed [ZW-1:0] vz_reg [0:N];
    logic signed [VW-1:0] vx_next [1:N];
    logic signed [VW-1:0] vy_next [1:N];
    logic signed [ZW-1:0] vz_next [1:N];
    // m1: angle and magnitude partial products
    logic               v6_reg;
    wdpu_pkg::item_t    pay6_reg;
    logic               zero6_reg;
    logic [8:0]         ang6_reg;
    logic [47:0]        ph6_reg;
    logic [46:0]        pl6_reg;
    // m2: course
    logic               v7_reg;
    wdpu_pkg::item_t    pay7_reg;
    logic [8:0]         cd7_reg;
    logic [16:0]        cs7_reg;
    // m3: step trig and speed times step
    logic               v8_reg;
    wdpu_pkg::item_t    pay8_reg;
    logic [8:0]         cd8_reg;
    logic [16:0]        cs8_reg;
    wdpu_pkg::trig_t    st8_reg;
    logic [24:0]        prod8_reg;
    // m4: displacement products
    logic               v9_reg;
    wdpu_pkg::item_t    pay9_reg;
    logic [8:0]         cd9_reg;
    logic [16:0]        cs9_reg;
    logic signed [41:0] qx9_reg, qy9_reg;
    // output register
    logic               vo_reg;
    logic signed [31:0] nx_reg, ny_reg, nz_reg;
    logic [8:0]         cdo_reg;
    logic [16:0]        cso_reg;

    // combinational helpers
    logic signed [33:0]    sx_sum, sy_sum;
    logic signed [XSW-1:0] xs_c, ys_c;
    logic signed [VW-1:0]  x0_c, y0_c;
    logic signed [ZW-1:0]  z0_c;
    logic [ZW-1:0]         zabs;
    logic [ZW-16:0]        rmag;
    logic signed [ZW-14:0] rsg;
    logic [8:0]            ang_c;
    logic [VW-1:0]         xpos;
    logic [65:0]           mfull;
    logic [21:0]           mag_c;
    logic [8:0]            a_c;
    logic signed [33:0]    tx_c, ty_c, sumx_c, sumy_c;

    // stall the whole pipe only while the output word waits
    assign en  = !vo_reg || m_tready;
    assign pop = en && head_valid;

    // vector sums, truncated toward zero
    always_comb begin
        sx_sum = 34'(pxh2_reg) + 34'(pxw2_reg);
        sy_sum = 34'(pyh2_reg) + 34'(pyw2_reg);
        xs_c   = XSW'((sx_sum + ((sx_sum < 0) ? 34'sd32767 : 34'sd0)) >>> 15);
        ys_c   = XSW'((sy_sum + ((sy_sum < 0) ? 34'sd32767 : 34'sd0)) >>> 15);
    end

    // fold into the right half plane and scale
    always_comb begin
        if (xs3_reg < 0) begin
            z0_c = (ys3_reg >= 0) ? ZW'(180 * 65536) : ZW'(-180 * 65536);
            x0_c = VW'(-xs3_reg) <<< 14;
            y0_c = VW'(-ys3_reg) <<< 14;
        end else begin
            z0_c = '0;
            x0_c = VW'(xs3_reg) <<< 14;
            y0_c = VW'(ys3_reg) <<< 14;
        end
    end

    // one micro-rotation per stage
    always_comb begin
        for (int i = 0; i < N; i++) begin
            if (vy_reg[i] >= 0) begin
                vx_next[i+1] = vx_reg[i] + (vy_reg[i] >>> i);
                vy_next[i+1] = vy_reg[i] - (vx_reg[i] >>> i);
                vz_next[i+1] = vz_reg[i] + ZW'(wdpu_pkg::ATAN_Q16[i]);
            end else begin
                vx_next[i+1] = vx_reg[i] - (vy_reg[i] >>> i);
                vy_next[i+1] = vy_reg[i] + (vx_reg[i] >>> i);
                vz_next[i+1] = vz_reg[i] - ZW'(wdpu_pkg::ATAN_Q16[i]);
            end
        end
    end

    // round angle to whole degrees, wrap to 0..359
    always_comb begin
        zabs = (vz_reg[N] < 0) ? ZW'(-vz_reg[N]) : ZW'(vz_reg[N]);
        rmag = (ZW-15)'((zabs + ZW'(32768)) >> 16);
        rsg  = (vz_reg[N] < 0) ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
        if (rsg < 0) begin
            ang_c = 9'(rsg + (ZW-13)'(360));
        end else if (rsg >= (ZW-13)'(360)) begin
            ang_c = 9'(rsg - (ZW-13)'(360));
        end else begin
            ang_c = 9'(rsg);
        end
        xpos = (vx_reg[N] < 0) ? '0 : VW'(vx_reg[N]);
    end

    // magnitude rounding; saturation follows in the course stage
    always_comb begin
        mfull = (66'(ph6_reg) << 17) + 66'(pl6_reg) + (66'd1 << 43);
        mag_c = mfull[65:44];
    end

    // step angle is 90 minus course, modulo 360
    assign a_c = (cd7_reg <= 9'd90) ? 9'd90 - cd7_reg : 9'd450 - cd7_reg;

    // displacement truncated toward zero, then saturated add
    always_comb begin
        tx_c   = 34'((qx9_reg + ((qx9_reg < 0) ? 42'sd32767 : 42'sd0)) >>> 15);
        ty_c   = 34'((qy9_reg + ((qy9_reg < 0) ? 42'sd32767 : 42'sd0)) >>> 15);
        sumx_c = 34'(pay9_reg.px) + tx_c;
        sumy_c = 34'(pay9_reg.py) + ty_c;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0;
            v9_reg <= 1'b0; vo_reg <= 1'b0;
            for (int i = 0; i <= N; i++) vv_reg[i] <= 1'b0;
        end else if (en) begin
            v1_reg    <= pop;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vv_reg[0] <= v3_reg;
            for (int i = 0; i < N; i++) vv_reg[i+1] <= vv_reg[i];
            v6_reg    <= vv_reg[N];
            v7_reg    <= v6_reg;
            v8_reg    <= v7_reg;
            v9_reg    <= v8_reg;
            vo_reg    <= v9_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            pay1_reg <= head_item;
            ht1_reg  <= wdpu_pkg::trig_lookup(head_item.hd);
            wt1_reg  <= wdpu_pkg::trig_lookup(head_item.wd);

            pay2_reg <= pay1_reg;
            pxh2_reg <= $signed({1'b0, pay1_reg.hs}) * ht1_reg.c;
            pxw2_reg <= $signed({1'b0, pay1_reg.ws}) * wt1_reg.c;
            pyh2_reg <= $signed({1'b0, pay1_reg.hs}) * ht1_reg.s;
            pyw2_reg <= $signed({1'b0, pay1_reg.ws}) * wt1_reg.s;

            pay3_reg <= pay2_reg;
            xs3_reg  <= xs_c;
            ys3_reg  <= ys_c;

            vpay_reg[0]  <= pay3_reg;
            vzero_reg[0] <= (xs3_reg == 0) && (ys3_reg == 0);
            vx_reg[0]    <= x0_c;
            vy_reg[0]    <= y0_c;
            vz_reg[0]    <= z0_c;
            for (int i = 0; i < N; i++) begin
                vpay_reg[i+1]  <= vpay_reg[i];
                vzero_reg[i+1] <= vzero_reg[i];
                vx_reg[i+1]    <= vx_next[i+1];
                vy_reg[i+1]    <= vy_next[i+1];
                vz_reg[i+1]    <= vz_next[i+1];
            end

            pay6_reg  <= vpay_reg[N];
            zero6_reg <= vzero_reg[N];
            ang6_reg  <= ang_c;
            ph6_reg   <= 48'(xpos[VW-2:17]) * 48'(wdpu_pkg::GAIN_Q30);
            pl6_reg   <= 47'(xpos[16:0]) * 47'(wdpu_pkg::GAIN_Q30);

            pay7_reg <= pay6_reg;
            if (pay6_reg.thermal) begin
                cd7_reg <= pay6_reg.wd;
                cs7_reg <= 17'(pay6_reg.ws);
            end else if (zero6_reg) begin
                cd7_reg <= '0;
                cs7_reg <= '0;
            end else begin
                cd7_reg <= ang6_reg;
                cs7_reg <= (mag_c > 22'd131071) ? 17'd131071 : mag_c[16:0];
            end

            pay8_reg  <= pay7_reg;
            cd8_reg   <= cd7_reg;
            cs8_reg   <= cs7_reg;
            st8_reg   <= wdpu_pkg::trig_lookup(a_c);
            prod8_reg <= 25'(cs7_reg) * 25'(time_step);

            pay9_reg <= pay8_reg;
            cd9_reg  <= cd8_reg;
            cs9_reg  <= cs8_reg;
            qx9_reg  <= $signed({1'b0, prod8_reg}) * st8_reg.c;
            qy9_reg  <= $signed({1'b0, prod8_reg}) * st8_reg.s;

            nx_reg  <= (sumx_c > 34'sd2147483647) ? 32'sh7FFFFFFF :
                       (sumx_c < -34'sd2147483648) ? 32'sh80000000 : 32'(sumx_c);
            ny_reg  <= (sumy_c > 34'sd2147483647) ? 32'sh7FFFFFFF :
                       (sumy_c < -34'sd2147483648) ? 32'sh80000000 : 32'(sumy_c);
            nz_reg  <= pay9_reg.pz;
            cdo_reg <= cd9_reg;
            cso_reg <= cs9_reg;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {6'd0, cso_reg, cdo_reg, nz_reg, ny_reg, nx_reg};

endmodule

/* sv/wind_drift_position_update_top.sv */
// ----------------------------------------------------------------------------
// wind_drift_position_update_top
// Wind cell store and position update for planes and thermal centers.
// ----------------------------------------------------------------------------
// Input words arrive on s_*: req_type in s_tuser selects a wind cell write,
// a plane move or a thermal move. Writes store speed and direction in one
// of 18 cells and give no output word; a move gives one output word on m_*
// with the new position, the copied elevation and the ground course.
// The user must write registers on cfg_* only while the block is idle; the
// block does not enforce this, and cfg_ready is always high.
// Throughput: one word per cycle while the output does not stall. A move
// passes from the queue to m_tvalid through three lookup, product and sum
// stages, one fold stage, one stage per CORDIC micro-rotation and five
// course and position stages.
// A four-entry queue separates the input side from the pipeline, so input
// words are still taken while an output word waits. While one waits with
// m_tready low the pipeline holds, the queue fills, s_tready falls when full.
// Reset clears the registers to their defaults and empties the pipeline;
// wind cells hold no defined value until written.
// ----------------------------------------------------------------------------
module wind_drift_position_update_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, heading_speed, heading_dir, cell_index,
    // cell_speed, cell_dir, zero pad
    input  logic [151:0] s_tdata,
    // req_type
    input  logic [1:0]   s_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_x, new_y, new_z, course_dir, course_speed, zero pad
    output logic [127:0] m_tdata
);

    logic            fifo_full, push_valid, head_valid, pop;
    wdpu_pkg::item_t push_item, head_item;
    logic [7:0]      time_step;

    wdpu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fifo_full  (fifo_full),
        .push_valid (push_valid),
        .push_item  (push_item),
        .time_step  (time_step)
    );

    wdpu_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_item  (push_item),
        .pop        (pop),
        .full       (fifo_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    wdpu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .time_step  (time_step),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
